/* rtl/core/fsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// FFT size round-up package
// Widths, limits and small arithmetic helpers shared by the divider and the
// smooth-number search.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam int unsigned DIV_W      = 32;
    localparam int unsigned QUO_W      = DIV_W + 1;
    localparam int unsigned STEP_W     = $clog2(DIV_W);
    localparam int unsigned MESH_W     = 17;
    localparam int unsigned MAX_POINTS = 65536;
    localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int unsigned SRCH_W     = CNT_W + 3;
    localparam int unsigned SH_W       = $clog2(SRCH_W);

    localparam logic [DIV_W-1:0] SPACING_RST = DIV_W'(65536);

    typedef logic [SRCH_W-1:0] t_srch;
    typedef logic [SH_W-1:0]   t_shamt;

    function automatic t_shamt msb_idx(input t_srch x);
        t_shamt r;
        r = '0;
        for (int i = 0; i < SRCH_W; i++) begin
            if (x[i]) begin
                r = SH_W'(i);
            end
        end
        return r;
    endfunction

    function automatic t_srch mul3(input t_srch x);
        return (x << 1) + x;
    endfunction

    function automatic t_srch mul5(input t_srch x);
        return (x << 2) + x;
    endfunction

    function automatic t_srch mul7(input t_srch x);
        return (x << 3) - x;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/fft_size_smooth_roundup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// FFT size round-up
// Divides a Q16.16 box length by the Q16.16 grid spacing, rounds the point
// count up, then rounds it up again to the next 2^a*3^b*5^c*7^d length.
// ----------------------------------------------------------------------------
// Usage:
//   Write the grid spacing with i_cfg_we/i_cfg_wdata while the block is idle;
//   reset loads 1.0 (65536).
//   Present i_box_size with start; the word is taken when start is high and
//   busy is low. busy stays high until the result is issued.
//   The result appears on o_mesh_points/o_too_large for one cycle with
//   o_valid; the receiver must take it then, it cannot stall the block.
// Sequence:
//   Zero box or zero spacing: result in the cycle after the accept.
//   Otherwise serial division (one quotient bit per cycle), an overflow
//   check, then a search over the odd 3/5/7 candidates, whose length grows
//   with the count.
//   One word is in flight at a time; the next is taken in the cycle the
//   result is issued.
// Reset: synchronous; clears the control state and drops any word in flight.
// ----------------------------------------------------------------------------
module fft_size_smooth_roundup (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [fsr_pkg::DIV_W-1:0]     i_box_size,
    input  wire logic                          i_cfg_we,
    input  wire logic [fsr_pkg::DIV_W-1:0]     i_cfg_wdata,
    output logic                               o_valid,
    output logic [fsr_pkg::MESH_W-1:0]         o_mesh_points,
    output logic                               o_too_large
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH
    } t_state;

    t_state                         r_state;
    logic [fsr_pkg::DIV_W-1:0]      r_spacing;
    logic                           r_valid;
    logic [fsr_pkg::MESH_W-1:0]     r_mesh;
    logic                           r_flag;
    fsr_pkg::t_srch                 r_count;
    fsr_pkg::t_shamt                r_cmsb;
    fsr_pkg::t_srch                 r_p7;
    fsr_pkg::t_srch                 r_p5;
    fsr_pkg::t_srch                 r_p3;
    fsr_pkg::t_srch                 r_best;

    logic                           w_accept;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [fsr_pkg::QUO_W-1:0]      w_quo_count;
    logic                           w_over;
    fsr_pkg::t_srch                 w_count_n;
    logic                           w_ge;
    fsr_pkg::t_shamt                w_dist;
    fsr_pkg::t_srch                 w_shl;
    fsr_pkg::t_srch                 w_cand;
    fsr_pkg::t_srch                 n_best;
    fsr_pkg::t_srch                 n_p5;
    fsr_pkg::t_srch                 n_p7;

    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_div_start = w_accept && (i_box_size != '0) && (r_spacing != '0);

    fsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_box_size),
        .i_divisor  (r_spacing),
        .o_done     (w_div_done),
        .o_count    (w_quo_count)
    );

    assign w_over    = w_quo_count > fsr_pkg::QUO_W'(fsr_pkg::MAX_POINTS);
    assign w_count_n = fsr_pkg::SRCH_W'(w_quo_count);

    always_comb begin
        w_ge   = (r_p3 >= r_count);
        w_dist = r_cmsb - fsr_pkg::msb_idx(r_p3);
        w_shl  = r_p3 << w_dist;
        if (w_ge) begin
            w_cand = r_p3;
        end else if (w_shl < r_count) begin
            w_cand = w_shl << 1;
        end else begin
            w_cand = w_shl;
        end
        n_best = (w_cand < r_best) ? w_cand : r_best;
        n_p5   = fsr_pkg::mul5(r_p5);
        n_p7   = fsr_pkg::mul7(r_p7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= fsr_pkg::SPACING_RST;
        end else if (i_cfg_we) begin
            r_spacing <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_box_size == '0) begin
                            r_valid <= 1'b1;
                            r_mesh  <= '0;
                            r_flag  <= 1'b0;
                        end else if (r_spacing == '0) begin
                            r_valid <= 1'b1;
                            r_mesh  <= '0;
                            r_flag  <= 1'b1;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (w_over) begin
                            r_valid <= 1'b1;
                            r_mesh  <= '0;
                            r_flag  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_count <= w_count_n;
                            r_cmsb  <= fsr_pkg::msb_idx(w_count_n);
                            r_p7    <= fsr_pkg::SRCH_W'(1);
                            r_p5    <= fsr_pkg::SRCH_W'(1);
                            r_p3    <= fsr_pkg::SRCH_W'(1);
                            r_best  <= '1;
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    r_best <= n_best;
                    if (!w_ge) begin
                        r_p3 <= fsr_pkg::mul3(r_p3);
                    end else if (r_p5 < r_count) begin
                        r_p5 <= n_p5;
                        r_p3 <= n_p5;
                    end else if (r_p7 < r_count) begin
                        r_p7 <= n_p7;
                        r_p5 <= n_p7;
                        r_p3 <= n_p7;
                    end else begin
                        r_valid <= 1'b1;
                        r_mesh  <= fsr_pkg::MESH_W'(n_best);
                        r_flag  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_mesh_points = r_mesh;
    assign o_too_large   = r_flag;

`ifndef SYNTHESIS
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_large |-> o_mesh_points == '0)
        else $error("overflow result carries a nonzero size");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted word neither in progress nor answered");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result issued while still busy");
`endif

endmodule
`default_nettype wire

/* rtl/core/fsr_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Serial ceiling divider
// Restoring divider, one quotient bit per cycle; returns the quotient
// rounded up when the remainder is nonzero.
// ----------------------------------------------------------------------------
module fsr_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fsr_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [fsr_pkg::DIV_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [fsr_pkg::QUO_W-1:0]         o_count
);

    logic                           r_run;
    logic                           r_done;
    logic [fsr_pkg::STEP_W-1:0]     r_step;
    logic [fsr_pkg::DIV_W-1:0]      r_quo;
    logic [fsr_pkg::DIV_W-1:0]      r_rem;
    logic [fsr_pkg::DIV_W-1:0]      r_dvsr;

    logic [fsr_pkg::DIV_W:0]        w_shift;
    logic [fsr_pkg::DIV_W+1:0]      w_diff;
    logic                           w_fit;

    assign w_shift = {r_rem, r_quo[fsr_pkg::DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvsr};
    assign w_fit   = !w_diff[fsr_pkg::DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvsr <= i_divisor;
            end else if (r_run) begin
                r_quo  <= {r_quo[fsr_pkg::DIV_W-2:0], w_fit};
                r_rem  <= w_fit ? w_diff[fsr_pkg::DIV_W-1:0] : w_shift[fsr_pkg::DIV_W-1:0];
                r_step <= r_step + 1'b1;
                if (r_step == fsr_pkg::STEP_W'(fsr_pkg::DIV_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_count = {1'b0, r_quo} + fsr_pkg::QUO_W'(r_rem != '0);

endmodule
`default_nettype wire
